>>> rtl/core/bounded_byte_stream_fifo_assert.svh
// Assertion macros for the bounded byte stream FIFO.
`ifndef BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH
`define BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bbsf_pkg.sv
// Package: action codes and fixed field widths for the byte stream FIFO.
`default_nettype none
package bbsf_pkg;
    localparam int ACT_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int LVL_W   = 13;
    localparam int TOT_W   = 64;

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [LVL_W-1:0]  t_level;
    typedef logic [TOT_W-1:0]  t_total;

    localparam t_action ACT_WRITE  = 3'd0;
    localparam t_action ACT_READ   = 3'd1;
    localparam t_action ACT_PEEK   = 3'd2;
    localparam t_action ACT_POP    = 3'd3;
    localparam t_action ACT_END    = 3'd4;
    localparam t_action ACT_STATUS = 3'd5;
endpackage
`default_nettype wire

>>> rtl/core/bounded_byte_stream_fifo.sv
// Bounded byte FIFO with end-of-stream flag: queue state, storage and result sequencing.
//
// Each item accepted (start high, busy low) gives its results on the following
// cycles, one per cycle, flagged by o_strobe; the receiver cannot stall them.
// Write, pop, end-input, status and reads or peeks that deliver nothing give a
// single result and may follow each other every cycle. A read or peek of n bytes
// gives n results on consecutive cycles, busy high on all but the last of them,
// since the byte store has a single, registered read port. Status fields
// on every result show the queue after the whole item. Storage needs no clearing
// after reset; only written entries are ever read. Capacity is written only while
// no result is pending and no item is offered; o_cfg_ready is high exactly then.
`default_nettype none
module bounded_byte_stream_fifo #(
    parameter int DEPTH     = 4096,
    parameter int MAX_BURST = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire  bbsf_pkg::t_action i_action,
    input  wire  bbsf_pkg::t_byte   i_data_in,
    input  wire  bbsf_pkg::t_len    i_length,
    output logic                 o_strobe,
    output bbsf_pkg::t_byte      o_data_out,
    output logic                 o_data_valid,
    output logic                 o_last,
    output logic                 o_accepted,
    output bbsf_pkg::t_level     o_fill_level,
    output bbsf_pkg::t_level     o_room_left,
    output logic                 o_ended_flag,
    output logic                 o_stream_done,
    output bbsf_pkg::t_total     o_total_written,
    output bbsf_pkg::t_total     o_total_read,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  bbsf_pkg::t_level  i_cfg_data
);
    import bbsf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > LVL_W) ? CW : LVL_W;
    localparam logic [WW:0]   DEPTH_S = (WW + 1)'(DEPTH);
    localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
    localparam t_len          BURST   = LEN_W'(MAX_BURST);

    // byte storage
    t_byte mem [DEPTH];

    logic [AW-1:0]  r_head;
    logic [CW-1:0]  r_held;
    logic [WW-1:0]  r_cap;
    logic           r_closed;
    t_total         r_wr_tot;
    t_total         r_rd_tot;

    logic           r_strobe;
    logic           r_dvalid;
    logic           r_last;
    logic           r_accepted;
    t_len           r_rem;
    logic [AW-1:0]  r_rd_ptr;
    t_byte          r_rdata;

    logic           accept;
    t_len           len_c;
    logic [WW-1:0]  held_w;
    logic [WW-1:0]  cap_eff;
    t_len           n_cnt;
    logic           can_write;
    logic [WW:0]    tail_sum;
    logic [AW-1:0]  tail;
    logic [WW:0]    head_sum;
    logic [AW-1:0]  head_adv;
    logic [AW-1:0]  ptr_inc;
    logic           is_fetch;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    assign accept    = start && !busy;
    assign busy      = r_strobe && (r_rem != '0);
    // capacity changes only with nothing in flight and no item offered
    assign o_cfg_ready = !r_strobe && !start;

    always_comb begin
        len_c    = (i_length > BURST) ? BURST : i_length;
        held_w   = WW'(r_held);
        cap_eff  = (r_cap > DEPTH_W) ? DEPTH_W : r_cap;
        n_cnt    = (WW'(len_c) < held_w) ? len_c : LEN_W'(held_w);
        can_write = held_w < cap_eff;
        tail_sum = {1'b0, WW'(r_head)} + {1'b0, held_w};
        tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
        head_sum = {1'b0, WW'(r_head)} + (WW + 1)'(n_cnt);
        head_adv = (head_sum >= DEPTH_S) ? AW'(head_sum - DEPTH_S) : AW'(head_sum);
        ptr_inc  = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        is_fetch = accept && (i_action inside {ACT_READ, ACT_PEEK})
                   && (n_cnt != '0);
        rd_en    = is_fetch || busy;
        rd_addr  = busy ? r_rd_ptr : r_head;
    end

    // storage port: write at tail, one read a cycle
    always_ff @(posedge i_clk) begin
        if (accept && i_action == ACT_WRITE && can_write) begin
            mem[tail] <= i_data_in;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // queue state, updated once per item at acceptance; capacity on a config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_held   <= '0;
            r_cap    <= DEPTH_W;
            r_closed <= 1'b0;
            r_wr_tot <= '0;
            r_rd_tot <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= WW'(i_cfg_data);
            end
            if (accept) begin
                case (i_action)
                    ACT_WRITE: begin
                        if (can_write) begin
                            r_held   <= r_held + 1'b1;
                            r_wr_tot <= r_wr_tot + 1'b1;
                        end
                    end
                    ACT_READ, ACT_POP: begin
                        r_head   <= head_adv;
                        r_held   <= CW'(held_w - WW'(n_cnt));
                        r_rd_tot <= r_rd_tot + TOT_W'(n_cnt);
                    end
                    ACT_END: begin
                        r_closed <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe   <= 1'b0;
            r_rem      <= '0;
            r_dvalid   <= 1'b0;
            r_last     <= 1'b0;
            r_accepted <= 1'b0;
            r_rd_ptr   <= '0;
        end else if (accept) begin
            r_strobe   <= 1'b1;
            r_accepted <= (i_action == ACT_WRITE) && can_write;
            if (is_fetch) begin
                r_dvalid <= 1'b1;
                r_rem    <= n_cnt - 1'b1;
                r_last   <= (n_cnt == LEN_W'(1));
                r_rd_ptr <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end else begin
                r_dvalid <= 1'b0;
                r_rem    <= '0;
                r_last   <= 1'b1;
            end
        end else if (busy) begin
            r_rem    <= r_rem - 1'b1;
            r_last   <= (r_rem == LEN_W'(1));
            r_rd_ptr <= ptr_inc;
        end else begin
            r_strobe <= 1'b0;
        end
    end

    logic [WW-1:0] room_w;
    assign room_w = (cap_eff > held_w) ? cap_eff - held_w : '0;

    assign o_strobe        = r_strobe;
    assign o_data_valid    = r_dvalid;
    assign o_data_out      = r_dvalid ? r_rdata : '0;
    assign o_last          = r_last;
    assign o_accepted      = r_accepted;
    assign o_fill_level    = LVL_W'(held_w);
    assign o_room_left     = LVL_W'(room_w);
    assign o_ended_flag    = r_closed;
    assign o_stream_done   = r_closed && (r_held == '0);
    assign o_total_written = r_wr_tot;
    assign o_total_read    = r_rd_tot;

`include "bounded_byte_stream_fifo_assert.svh"

    `BBSF_ASSERT_IMP(a_busy_in_burst, busy, r_strobe && r_dvalid, "busy outside a byte burst")
    `BBSF_ASSERT_IMP(a_last_frees, r_strobe && r_last, !busy, "busy on the last result")
    `BBSF_ASSERT_NXT(a_item_answers, accept, r_strobe, "accepted item gave no result")
    `BBSF_ASSERT_IMP(a_fill_bound, 1'b1, held_w <= DEPTH_W, "fill above storage depth")
endmodule
`default_nettype wire

>>> verif/bounded_byte_stream_fifo_tb.sv
// Testbench for the bounded byte stream FIFO: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module bounded_byte_stream_fifo_tb;
    import bbsf_pkg::*;

    localparam int FIFO_DEPTH = 4096;
    localparam int BURST_MAX  = 64;

    // codes 6 and 7 have no name in the package; the block treats them as status
    localparam t_action ACT_SPARE_LO = 3'd6;
    localparam t_action ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        t_byte  data;
        logic   valid;
        logic   last;
        logic   acc;
        t_level fill;
        t_level room;
        logic   ended;
        logic   done;
        t_total wr_tot;
        t_total rd_tot;
    } t_fifo_result;

    typedef struct {
        t_action      act;
        t_byte        din;
        t_len         len;
        bit           typed;
        t_fifo_result want;
    } t_step_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_action i_action = ACT_STATUS;
    t_byte   i_data_in = '0;
    t_len    i_length = '0;
    logic    o_strobe;
    t_byte   o_data_out;
    logic    o_data_valid;
    logic    o_last;
    logic    o_accepted;
    t_level  o_fill_level;
    t_level  o_room_left;
    logic    o_ended_flag;
    logic    o_stream_done;
    t_total  o_total_written;
    t_total  o_total_read;
    logic    i_cfg_valid = 1'b0;
    logic    o_cfg_ready;
    t_level  i_cfg_data = '0;

    bounded_byte_stream_fifo u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_data_in       (i_data_in),
        .i_length        (i_length),
        .o_strobe        (o_strobe),
        .o_data_out      (o_data_out),
        .o_data_valid    (o_data_valid),
        .o_last          (o_last),
        .o_accepted      (o_accepted),
        .o_fill_level    (o_fill_level),
        .o_room_left     (o_room_left),
        .o_ended_flag    (o_ended_flag),
        .o_stream_done   (o_stream_done),
        .o_total_written (o_total_written),
        .o_total_read    (o_total_read),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted queue state
    t_byte        store_bytes [0:FIFO_DEPTH-1];
    int           head_pos = 0;
    int           held = 0;
    t_total       written_tot = '0;
    t_total       read_tot = '0;
    bit           closed = 1'b0;
    t_level       cap_reg = t_level'(FIFO_DEPTH);
    t_fifo_result due_results [$];
    int           errors = 0;
    int           sender_idle = 0;

    // side info riding with the item being offered
    bit           row_typed = 1'b0;
    t_fifo_result row_want = '0;

    function automatic t_fifo_result status_only(logic acc, int fill, int room, logic ended,
                                                 logic done, t_total wt, t_total rt);
        t_fifo_result r;
        r = '0;
        r.last   = 1'b1;
        r.acc    = acc;
        r.fill   = t_level'(fill);
        r.room   = t_level'(room);
        r.ended  = ended;
        r.done   = done;
        r.wr_tot = wt;
        r.rd_tot = rt;
        return r;
    endfunction

    // Apply one item to the predicted queue and queue up the results it gives.
    task automatic apply_item(t_action act, t_byte din, t_len len_in, bit typed,
                              t_fifo_result want);
        t_byte        got [0:BURST_MAX-1];
        int           burst;
        int           n;
        int           cap_eff;
        int           k;
        logic         acc;
        t_fifo_result r;
        burst   = (len_in > BURST_MAX) ? BURST_MAX : int'(len_in);
        cap_eff = (cap_reg > FIFO_DEPTH) ? FIFO_DEPTH : int'(cap_reg);
        acc     = 1'b0;
        n       = 0;
        case (act)
            ACT_WRITE: begin
                if (held < cap_eff) begin
                    store_bytes[(head_pos + held) % FIFO_DEPTH] = din;
                    held++;
                    written_tot++;
                    acc = 1'b1;
                end
            end
            ACT_READ, ACT_PEEK: begin
                n = (burst < held) ? burst : held;
                for (k = 0; k < n; k++)
                    got[k] = store_bytes[(head_pos + k) % FIFO_DEPTH];
                if (act == ACT_READ) begin
                    head_pos = (head_pos + n) % FIFO_DEPTH;
                    held -= n;
                    read_tot += t_total'(n);
                end
            end
            ACT_POP: begin
                k = (burst < held) ? burst : held;
                head_pos = (head_pos + k) % FIFO_DEPTH;
                held -= k;
                read_tot += t_total'(k);
            end
            ACT_END: closed = 1'b1;
            default: ;
        endcase
        // status fields show the queue after the whole item
        r = status_only(acc, held, (cap_eff > held) ? cap_eff - held : 0, closed,
                        closed && held == 0, written_tot, read_tot);
        if (typed) begin
            due_results.insert(due_results.size(), want);
        end else if (n > 0) begin
            for (k = 0; k < n; k++) begin
                r.data  = got[k];
                r.valid = 1'b1;
                r.last  = (k == n - 1);
                due_results.insert(due_results.size(), r);
            end
        end else begin
            due_results.insert(due_results.size(), r);
        end
    endtask

    task automatic show_result(string tag, t_fifo_result r);
        $display("%0t   %s data=%h valid=%b last=%b acc=%b fill=%0d room=%0d",
                 $time, tag, r.data, r.valid, r.last, r.acc, r.fill, r.room,
                 " ended=%b done=%b wr=%0d rd=%0d", r.ended, r.done, r.wr_tot, r.rd_tot);
    endtask

    always @(posedge i_clk) begin
        t_fifo_result want;
        t_fifo_result got;
        if (i_rst_n) begin
            if (o_strobe) begin
                got = '{o_data_out, o_data_valid, o_last, o_accepted, o_fill_level, o_room_left,
                        o_ended_flag, o_stream_done, o_total_written, o_total_read};
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= 20) begin
                        $display("%0t unexpected result, nothing pending", $time);
                        show_result("actual:  ", got);
                    end
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    if (got !== want) begin
                        errors++;
                        if (errors <= 20) begin
                            $display("%0t result mismatch", $time);
                            show_result("expected:", want);
                            show_result("actual:  ", got);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                cap_reg = i_cfg_data;
            if (start && !busy)
                apply_item(i_action, i_data_in, i_length, row_typed, row_want);
        end
    end

    task automatic send_item(t_action act, t_byte din, t_len len, bit typed,
                             t_fifo_result want);
        @(negedge i_clk);
        if (sender_idle != 0 && $urandom_range(0, 99) < sender_idle) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start     = 1'b1;
        i_action  = act;
        i_data_in = din;
        i_length  = len;
        row_typed = typed;
        row_want  = want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // hold off the sender until every pending result has come out
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(t_level value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_random();
        int      pick;
        int      span;
        t_action act;
        t_len    len;
        pick = $urandom_range(0, 99);
        if (pick < 50)      act = ACT_WRITE;
        else if (pick < 68) act = ACT_READ;
        else if (pick < 78) act = ACT_PEEK;
        else if (pick < 86) act = ACT_POP;
        else if (pick < 88) act = ACT_END;
        else if (pick < 94) act = ACT_STATUS;
        else if (pick < 97) act = ACT_SPARE_LO;
        else                act = ACT_SPARE_HI;
        // mostly short bursts, some up to the burst limit and some over-long requests
        span = $urandom_range(0, 19);
        if (span < 16)      len = t_len'($urandom_range(0, 12));
        else if (span < 19) len = t_len'($urandom_range(13, BURST_MAX));
        else                len = t_len'($urandom_range(BURST_MAX + 1, 127));
        send_item(act, t_byte'($urandom_range(0, 255)), len, 1'b0, '0);
    endtask

    task automatic run_phase(t_level cap, int count);
        set_capacity(cap);
        repeat (count) begin
            if ($urandom_range(0, 49) == 0)
                drain_results();
            send_random();
        end
    endtask

    initial begin
        t_step_row rows [$];
        t_fifo_result none;
        none = '0;
        rows.insert(rows.size(), t_step_row'{ACT_STATUS, 8'h00, 7'd0, 1'b1,
                    status_only(1'b0, 0, 4096, 1'b0, 1'b0, 64'd0, 64'd0)});
        rows.insert(rows.size(), t_step_row'{ACT_READ, 8'h00, 7'd5, 1'b1,
                    status_only(1'b0, 0, 4096, 1'b0, 1'b0, 64'd0, 64'd0)});
        rows.insert(rows.size(), t_step_row'{ACT_PEEK, 8'h00, 7'd0, 1'b1,
                    status_only(1'b0, 0, 4096, 1'b0, 1'b0, 64'd0, 64'd0)});
        rows.insert(rows.size(), t_step_row'{ACT_POP, 8'h00, 7'd3, 1'b1,
                    status_only(1'b0, 0, 4096, 1'b0, 1'b0, 64'd0, 64'd0)});
        rows.insert(rows.size(), t_step_row'{ACT_WRITE, 8'h00, 7'd0, 1'b1,
                    status_only(1'b1, 1, 4095, 1'b0, 1'b0, 64'd1, 64'd0)});
        rows.insert(rows.size(), t_step_row'{ACT_WRITE, 8'hFF, 7'd0, 1'b1,
                    status_only(1'b1, 2, 4094, 1'b0, 1'b0, 64'd2, 64'd0)});
        rows.insert(rows.size(), t_step_row'{ACT_WRITE, 8'hA5, 7'd0, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_WRITE, 8'h5A, 7'd0, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_PEEK, 8'h00, 7'd2, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_READ, 8'h00, 7'd0, 1'b1,
                    status_only(1'b0, 4, 4092, 1'b0, 1'b0, 64'd4, 64'd0)});
        rows.insert(rows.size(), t_step_row'{ACT_READ, 8'h00, 7'd1, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_POP, 8'h00, 7'd1, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_READ, 8'h00, 7'd127, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_SPARE_LO, 8'h00, 7'd0, 1'b1,
                    status_only(1'b0, 0, 4096, 1'b0, 1'b0, 64'd4, 64'd4)});
        rows.insert(rows.size(), t_step_row'{ACT_SPARE_HI, 8'h00, 7'd0, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_WRITE, 8'h3C, 7'd0, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_END, 8'h00, 7'd0, 1'b1,
                    status_only(1'b0, 1, 4095, 1'b1, 1'b0, 64'd5, 64'd4)});
        // write after end of input still goes in
        rows.insert(rows.size(), t_step_row'{ACT_WRITE, 8'hC3, 7'd0, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_READ, 8'h00, 7'd64, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_STATUS, 8'h00, 7'd0, 1'b1,
                    status_only(1'b0, 0, 4096, 1'b1, 1'b1, 64'd6, 64'd6)});
        rows.insert(rows.size(), t_step_row'{ACT_WRITE, 8'h11, 7'd0, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_POP, 8'h00, 7'd0, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_PEEK, 8'h00, 7'd64, 1'b0, none});
        rows.insert(rows.size(), t_step_row'{ACT_POP, 8'h00, 7'd64, 1'b0, none});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        sender_idle = 10;
        foreach (rows[i])
            send_item(rows[i].act, rows[i].din, rows[i].len, rows[i].typed, rows[i].want);

        // register above the store size clamps, zero refuses every write
        run_phase(t_level'(8191), 100);
        run_phase(t_level'(0), 25);
        sender_idle = 66;
        run_phase(t_level'(1), 40);
        run_phase(t_level'(16), 100);
        sender_idle = 0;
        // fill up, then drop the capacity below the fill level
        repeat (16) send_item(ACT_WRITE, t_byte'($urandom_range(0, 255)), '0, 1'b0, '0);
        run_phase(t_level'(3), 50);
        run_phase(t_level'(FIFO_DEPTH), 80);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bbsf_pkg.sv
rtl/core/bounded_byte_stream_fifo.sv
verif/bounded_byte_stream_fifo_tb.sv
